// File: rtl/next_fit_slot_allocator_top_defines.svh
// Assertion helpers for the slot allocator.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`define NFSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define NFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nfsa_pkg.sv
package nfsa_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 2048;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = 5;
  localparam int unsigned SLOT_W        = 11;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic free_chk;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } stat_t;

endpackage

// File: rtl/nfsa_ctrl.sv
module nfsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            op,
  output logic            busy,
  output nfsa_pkg::ctl_t  ctl,
  input  nfsa_pkg::stat_t stat
);
  import nfsa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = (op == OP_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        ctl.free_chk = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: rtl/nfsa_dp.sv
module nfsa_dp #(
  parameter int unsigned NUM_SLOTS = nfsa_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nfsa_pkg::ctl_t                  ctl,
  output nfsa_pkg::stat_t                 stat,
  input  logic                            in_op,
  input  logic [nfsa_pkg::SLOT_W-1:0]     in_slot_index,
  output logic                            out_valid,
  output logic [nfsa_pkg::SLOT_W-1:0]     out_slot_out,
  output logic [nfsa_pkg::STATUS_W-1:0]   out_status,
  output logic [nfsa_pkg::COUNT_W-1:0]    out_slots_in_use
);
  import nfsa_pkg::*;

  localparam int unsigned NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned CCW       = $clog2(NUM_WORDS + 1);
  localparam int unsigned CW        = $clog2(NUM_SLOTS + 1);
  localparam int unsigned PW        = AW + BIT_W;
  localparam int unsigned TAIL      = NUM_SLOTS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK = ~({WORD_W{1'b1}} >> (WORD_W - TAIL));
  localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [CCW-1:0]    LAST_CNT  = CCW'(NUM_WORDS);

  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;

  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     chk_addr_r;
  logic [CCW-1:0]    chk_cnt_r;
  logic [AW-1:0]     start_word_r;
  logic [AW-1:0]     start_word_nxt;
  logic [BIT_W-1:0]  start_bit_r;
  logic [BIT_W-1:0]  start_bit_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [SLOT_W-1:0] idx_r;
  logic              idx_ok_r;
  logic              idx_ok;
  logic [AW-1:0]     idx_word;

  logic [WORD_W-1:0] low_mask;
  logic [WORD_W-1:0] eff;
  logic [WORD_W-1:0] free_vec;
  logic              hit;
  logic [BIT_W-1:0]  hit_bit;
  logic              scan_last;
  logic [BIT_W-1:0]  idx_bit;
  logic              free_set;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [SLOT_W-1:0]   out_slot_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r;

  assign idx_ok   = (32'(in_slot_index) < NUM_SLOTS);
  assign idx_word = AW'(in_slot_index >> BIT_W);
  assign idx_bit  = idx_r[BIT_W-1:0];

  always_comb begin
    if (ctl.accept) begin
      if (in_op == OP_ALLOC) begin
        rd_addr = start_word_r;
      end else begin
        rd_addr = idx_ok ? idx_word : '0;
      end
    end else begin
      rd_addr = (chk_addr_r == LAST_WORD) ? '0 : chk_addr_r + AW'(1);
    end
  end

  // first word skips bits below the start; the closing revisit covers only them
  assign low_mask  = (WORD_W'(1) << start_bit_r) - WORD_W'(1);
  assign eff       = rd_data_r
                   | ((chk_cnt_r == '0) ? low_mask : '0)
                   | ((chk_cnt_r == LAST_CNT) ? ~low_mask : '0)
                   | ((chk_addr_r == LAST_WORD) ? TAIL_MASK : '0);
  assign free_vec  = ~eff;
  assign hit       = |free_vec;
  assign hit_bit   = first_one(free_vec);
  assign scan_last = (chk_cnt_r == LAST_CNT);
  assign free_set  = idx_ok_r & rd_data_r[idx_bit];

  assign stat.clear_done = (clr_addr_r == LAST_WORD);
  assign stat.scan_done  = hit | scan_last;

  always_comb begin
    we             = 1'b0;
    wa             = chk_addr_r;
    wd             = rd_data_r;
    start_word_nxt = start_word_r;
    start_bit_nxt  = start_bit_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    if (ctl.clear) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else if (ctl.scan) begin
      if (hit) begin
        we             = 1'b1;
        wd             = rd_data_r | (WORD_W'(1) << hit_bit);
        start_word_nxt = chk_addr_r;
        start_bit_nxt  = hit_bit;
        count_nxt      = count_r + CW'(1);
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = SLOT_W'(PW'({chk_addr_r, hit_bit}));
        out_status_nxt = STAT_OK;
      end else if (scan_last) begin
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = '0;
        out_status_nxt = STAT_FULL;
      end
    end else if (ctl.free_chk) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = idx_r;
      if (free_set) begin
        we             = 1'b1;
        wd             = rd_data_r & ~(WORD_W'(1) << idx_bit);
        count_nxt      = count_r - CW'(1);
        out_status_nxt = STAT_OK;
      end else begin
        out_status_nxt = STAT_NOT_USED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      start_word_r <= '0;
      start_bit_r  <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      start_word_r <= start_word_nxt;
      start_bit_r  <= start_bit_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r   <= rd_addr;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= COUNT_W'(count_nxt);
    if (ctl.accept) begin
      chk_cnt_r <= '0;
      idx_r     <= in_slot_index;
      idx_ok_r  <= idx_ok;
    end else begin
      chk_cnt_r <= chk_cnt_r + CCW'(1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_out     = out_slot_r;
  assign out_status       = out_status_r;
  assign out_slots_in_use = out_count_r;

endmodule

// File: rtl/next_fit_slot_allocator_top.sv
// Next-fit slot allocator over an occupancy bitmap held in a 32-bit-wide memory.
// Input: start with in_op / in_slot_index; the item is taken at a clock edge
// where start is high and busy is low. in_op 0 allocates, 1 frees in_slot_index.
// Output: out_valid pulses for one cycle with out_slot_out, out_status and
// out_slots_in_use; exactly one result per item. The receiver cannot stall,
// so every result must be captured in its strobe cycle.
// Allocate: the item is taken, then one bitmap word is checked per cycle
// starting at the word of the last slot handed out, up to ceil(NUM_SLOTS/32)+1
// words; the result is shown in the next cycle. The scan rate is set by the
// single read port of the bitmap memory.
// Free: the word is read at the accept edge, then checked and updated in the
// S_FREE state, from which the result strobe is registered.
// busy falls in the cycle the result is shown, so the next item may start then.
// Reset: synchronous, active low. After reset the block sweeps the bitmap to
// zero, one word per cycle, ceil(NUM_SLOTS/32) words (64 at 2048), with busy
// high; search start and in-use count reset to zero.
`include "next_fit_slot_allocator_top_defines.svh"

module next_fit_slot_allocator_top #(
  parameter int unsigned NUM_SLOTS = nfsa_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [nfsa_pkg::SLOT_W-1:0]   in_slot_index,
  output logic                          out_valid,
  output logic [nfsa_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [nfsa_pkg::STATUS_W-1:0] out_status,
  output logic [nfsa_pkg::COUNT_W-1:0]  out_slots_in_use
);
  import nfsa_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  nfsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  nfsa_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_op            (in_op),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_slot_out     (out_slot_out),
    .out_status       (out_status),
    .out_slots_in_use (out_slots_in_use)
  );

  `NFSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `NFSA_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while busy")
  `NFSA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `NFSA_ASSERT_SAME(a_full_count, out_valid && (out_status == STAT_FULL), out_slots_in_use == COUNT_W'(NUM_SLOTS), "full reported with free slots")

endmodule

// File: sim/tb_next_fit_slot_allocator_top.sv
`timescale 1ns / 1ps

module tb_next_fit_slot_allocator_top;
  import nfsa_pkg::*;

  localparam int unsigned SLOTS = NUM_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int N_DIR = 16;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } slot_result_t;

  typedef struct {
    slot_result_t res;
    int           stamp;
  } pending_result_t;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] idx;
    logic              typed;
    slot_result_t      res;
  } dir_row_t;

  // typed rows hold results that follow directly from a fresh map
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{OP_ALLOC, 11'd0,    1'b1, '{11'd0,    STAT_OK,       12'd1}},
    '{OP_ALLOC, 11'd2047, 1'b1, '{11'd1,    STAT_OK,       12'd2}},
    '{OP_FREE,  11'd0,    1'b1, '{11'd0,    STAT_OK,       12'd1}},
    '{OP_FREE,  11'd0,    1'b1, '{11'd0,    STAT_NOT_USED, 12'd1}},
    '{OP_FREE,  11'd2047, 1'b1, '{11'd2047, STAT_NOT_USED, 12'd1}},
    '{OP_ALLOC, 11'd1365, 1'b0, '0},
    '{OP_ALLOC, 11'd682,  1'b0, '0},
    '{OP_FREE,  11'd1,    1'b0, '0},
    '{OP_FREE,  11'd2,    1'b0, '0},
    '{OP_ALLOC, 11'd0,    1'b0, '0},
    '{OP_FREE,  11'd1024, 1'b0, '0},
    '{OP_FREE,  11'd4,    1'b0, '0},
    '{OP_FREE,  11'd3,    1'b0, '0},
    '{OP_ALLOC, 11'd2047, 1'b0, '0},
    '{OP_FREE,  11'd4,    1'b0, '0},
    '{OP_FREE,  11'd1365, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                in_op = 1'b0;
  logic [SLOT_W-1:0]   in_slot_index = '0;
  logic                busy;
  logic                out_valid;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_slots_in_use;

  next_fit_slot_allocator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_slot_out     (out_slot_out),
    .out_status       (out_status),
    .out_slots_in_use (out_slots_in_use)
  );

  always #6 clk = ~clk;

  // allocator shadow state
  bit                 slot_taken [SLOTS];
  logic [SLOT_W-1:0]  search_pos = '0;
  logic [COUNT_W-1:0] taken_count = '0;
  logic [SLOT_W-1:0]  held_slots [$];

  pending_result_t    pending_results [$];
  int                 cyc = 0;
  int                 idle_cycles = 0;
  int                 n_sent = 0;
  int                 n_done = 0;
  int                 n_fail = 0;
  int                 n_alloc = 0;
  int                 n_full = 0;
  int                 n_free = 0;
  int                 n_free_bad = 0;
  bit                 burst = 1'b0;

  function automatic slot_result_t model_request(input logic op,
                                                 input logic [SLOT_W-1:0] idx);
    slot_result_t r;
    int unsigned  pos;
    int unsigned  n;
    int           k;
    r = '{slot: '0, status: STAT_FULL, count: taken_count};
    if (op == OP_ALLOC) begin
      pos = search_pos;
      for (n = 0; n < SLOTS; n++) begin
        if (!slot_taken[pos]) begin
          slot_taken[pos] = 1'b1;
          taken_count = taken_count + 1'b1;
          search_pos = pos[SLOT_W-1:0];
          held_slots.push_back(pos[SLOT_W-1:0]);
          r = '{slot: pos[SLOT_W-1:0], status: STAT_OK, count: taken_count};
          return r;
        end
        pos = (pos + 1) % SLOTS;
      end
      return r;
    end
    r.slot = idx;
    if (idx < SLOTS && slot_taken[idx]) begin
      slot_taken[idx] = 1'b0;
      if (taken_count != 0) taken_count = taken_count - 1'b1;
      for (k = 0; k < held_slots.size(); k++) begin
        if (held_slots[k] == idx) begin
          held_slots.delete(k);
          break;
        end
      end
      r.status = STAT_OK;
    end else begin
      r.status = STAT_NOT_USED;
    end
    r.count = taken_count;
    return r;
  endfunction

  function automatic int next_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // called at a rising edge; returns at the edge that takes the item
  task automatic issue(input logic op, input logic [SLOT_W-1:0] idx, input logic typed,
                       input slot_result_t typed_res);
    int           gap;
    slot_result_t want;
    if (n_sent % 64 == 0) burst = ($urandom_range(3) == 0);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_slot_index <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    want = model_request(op, idx);
    if (op == OP_ALLOC) begin
      n_alloc++;
      if (want.status == STAT_FULL) n_full++;
    end else begin
      n_free++;
      if (want.status == STAT_NOT_USED) n_free_bad++;
    end
    if (typed) want = typed_res;
    pending_results.push_back('{res: want, stamp: cyc});
    n_sent++;
  endtask

  task automatic random_request(input int alloc_pct);
    logic [SLOT_W-1:0] idx;
    idx = SLOT_W'($urandom_range(SLOTS - 1));
    if ($urandom_range(99) < alloc_pct)
      issue(OP_ALLOC, idx, 1'b0, '0);
    else if (held_slots.size() > 0 && $urandom_range(9) < 8)
      issue(OP_FREE, held_slots[$urandom_range(held_slots.size() - 1)], 1'b0, '0);
    else
      issue(OP_FREE, idx, 1'b0, '0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (n_done != n_sent) @(posedge clk);
  endtask

  always @(posedge clk) cyc <= cyc + 1;

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      if (pending_results.size() == 0 || pending_results[0].stamp == cyc) begin
        $error("unexpected result: slot_out %0d status %0d slots_in_use %0d",
               out_slot_out, out_status, out_slots_in_use);
        n_fail++;
      end else begin
        if (out_slot_out !== pending_results[0].res.slot) begin
          $error("slot_out: expected %0d, got %0d", pending_results[0].res.slot, out_slot_out);
          n_fail++;
        end
        if (out_status !== pending_results[0].res.status) begin
          $error("status: expected %0d, got %0d", pending_results[0].res.status, out_status);
          n_fail++;
        end
        if (out_slots_in_use !== pending_results[0].res.count) begin
          $error("slots_in_use: expected %0d, got %0d", pending_results[0].res.count,
                 out_slots_in_use);
          n_fail++;
        end
        void'(pending_results.pop_front());
        n_done <= n_done + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++)
      issue(DIR_TAB[i].op, DIR_TAB[i].idx, DIR_TAB[i].typed, DIR_TAB[i].res);
    drain();

    for (i = 0; i < 700; i++) begin
      random_request(75);
      if (i == 350) drain();
    end

    for (i = 0; i < 334; i++) random_request(45);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_results.size() != 0) begin
      $error("missing result: slot_out %0d status %0d slots_in_use %0d",
             pending_results[0].res.slot, pending_results[0].res.status,
             pending_results[0].res.count);
      n_fail++;
      void'(pending_results.pop_front());
    end

    $display("Covered %0d items: %0d allocations (%0d on a full map), %0d frees (%0d not in use).",
             n_sent, n_alloc, n_full, n_free, n_free_bad);
    $display("Directed corner rows, then allocate-heavy and mixed churn with gaps, bursts, drains.");
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/nfsa_pkg.sv
rtl/nfsa_ctrl.sv
rtl/nfsa_dp.sv
rtl/next_fit_slot_allocator_top.sv
sim/tb_next_fit_slot_allocator_top.sv
